/* rtl/canvas_raster_draw_engine_defines.svh */
// assertion macros for the raster draw engine checker
// no dependencies; included by files that assert
`ifndef CANVAS_RASTER_DRAW_ENGINE_DEFINES_SVH
`define CANVAS_RASTER_DRAW_ENGINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CRDE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crde assertion failed");

// next-cycle implication, disabled in reset
`define CRDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crde assertion failed");

`endif

/* rtl/crde_pkg.sv */
// shared types, constants and helpers of the raster draw engine
// no dependencies
package crde_pkg;

    localparam int CANVAS_ROWS_DEF = 32;
    localparam int CANVAS_COLS_DEF = 64;

    localparam logic [2:0] SHADE_WHITE = 3'd4;
    localparam int         SHADE_MAX   = 4;

    localparam int ANG_FULL = 360;
    localparam int ANG_HALF = 180;
    localparam int ANG_STEP = 45;

    typedef enum logic [2:0] {
        MODE_ELLIPSE = 3'd0,
        MODE_LINE    = 3'd1,
        MODE_SQUARE  = 3'd2,
        MODE_SHADE   = 3'd3,
        MODE_COPY    = 3'd4,
        MODE_READ    = 3'd5
    } t_mode;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_DECIDE,
        S_WALK,
        S_CPWR,
        S_ELL,
        S_RDWAIT,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        FS_SQ_A1 = 3'd0,
        FS_SQ_B1 = 3'd1,
        FS_SQ_A2 = 3'd2,
        FS_SQ_B2 = 3'd3,
        FS_SQ_H  = 3'd4,
        FS_HHB   = 3'd5,
        FS_SQ_C  = 3'd6,
        FS_JUDGE = 3'd7
    } t_fstep;

    typedef struct packed {
        logic done;
        logic hit;
    } t_focal_stat;

    // row step for heading index 0..7 (0 = up, clockwise)
    function automatic logic signed [1:0] step_row(input logic [2:0] k);
        case (k)
            3'd0, 3'd1, 3'd7: step_row = -2'sd1;
            3'd3, 3'd4, 3'd5: step_row = 2'sd1;
            default:          step_row = 2'sd0;
        endcase
    endfunction

    function automatic logic signed [1:0] step_col(input logic [2:0] k);
        case (k)
            3'd1, 3'd2, 3'd3: step_col = 2'sd1;
            3'd5, 3'd6, 3'd7: step_col = -2'sd1;
            default:          step_col = 2'sd0;
        endcase
    endfunction

endpackage

/* rtl/crde_focal_unit.sv */
// exact two-focus distance test for one pixel on a shared multiplier
// depends on crde_pkg
module crde_focal_unit
    import crde_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic signed [7:0] i_row_1,
    input  logic signed [7:0] i_col_1,
    input  logic signed [7:0] i_row_2,
    input  logic signed [7:0] i_col_2,
    input  logic signed [11:0] i_half_q4,
    input  logic              i_filled,
    input  logic signed [7:0] i_pix_row,
    input  logic signed [7:0] i_pix_col,
    output t_focal_stat       o_stat
);

    logic        r_busy;
    t_fstep      r_step;
    t_fstep      cur_step;

    logic [17:0] r_sa, r_sb;
    logic [22:0] r_hh;
    logic signed [25:0] r_c;
    logic [47:0] r_lhs, r_rhs;

    logic signed [8:0]  a1, b1, a2, b2;
    logic [23:0]        big_a, big_b;
    logic signed [26:0] op_x, op_y;
    logic signed [53:0] prod;
    logic [47:0]        lhs4;

    assign a1 = 9'(i_row_1) - 9'(i_pix_row);
    assign b1 = 9'(i_col_1) - 9'(i_pix_col);
    assign a2 = 9'(i_row_2) - 9'(i_pix_row);
    assign b2 = 9'(i_col_2) - 9'(i_pix_col);

    // squared distances scaled by 64
    assign big_a = {r_sa, 6'b0};
    assign big_b = {r_sb, 6'b0};

    assign cur_step = r_busy ? r_step : FS_SQ_A1;

    always_comb begin
        op_x = '0;
        op_y = '0;
        case (cur_step)
            FS_SQ_A1: begin op_x = 27'(a1); op_y = 27'(a1); end
            FS_SQ_B1: begin op_x = 27'(b1); op_y = 27'(b1); end
            FS_SQ_A2: begin op_x = 27'(a2); op_y = 27'(a2); end
            FS_SQ_B2: begin op_x = 27'(b2); op_y = 27'(b2); end
            FS_SQ_H:  begin op_x = 27'(i_half_q4); op_y = 27'(i_half_q4); end
            FS_HHB:   begin op_x = 27'(r_hh); op_y = 27'(big_b); end
            FS_SQ_C:  begin op_x = 27'(r_c); op_y = 27'(r_c); end
            default:  begin op_x = '0; op_y = '0; end
        endcase
    end

    assign prod = op_x * op_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= FS_SQ_A1;
        end else if (i_start && !r_busy) begin
            r_busy <= 1'b1;
            r_step <= FS_SQ_B1;
        end else if (r_busy) begin
            if (r_step == FS_JUDGE) begin
                r_busy <= 1'b0;
                r_step <= FS_SQ_A1;
            end else begin
                r_step <= t_fstep'(r_step + 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start || r_busy) begin
            case (cur_step)
                FS_SQ_A1: r_sa <= 18'(prod);
                FS_SQ_B1: r_sa <= r_sa + 18'(prod);
                FS_SQ_A2: r_sb <= 18'(prod);
                FS_SQ_B2: r_sb <= r_sb + 18'(prod);
                FS_SQ_H:  r_hh <= 23'(prod);
                FS_HHB: begin
                    r_lhs <= 48'(prod);
                    r_c   <= $signed(26'(r_hh) + 26'(big_b) - 26'(big_a));
                end
                FS_SQ_C:  r_rhs <= 48'(prod);
                default:  ;
            endcase
        end
    end

    assign lhs4 = {r_lhs[45:0], 2'b00};

    assign o_stat.done = r_busy && (r_step == FS_JUDGE);
    assign o_stat.hit  = !i_half_q4[11] && !(24'(r_hh) < big_b) && !r_c[25]
                         && (i_filled ? (lhs4 <= r_rhs) : (lhs4 == r_rhs));

endmodule

/* rtl/canvas_raster_draw_engine.sv */
// Raster draw engine: a CANVAS_ROWS x CANVAS_COLS canvas of 3-bit shades in a
// single-port memory plus a pen shade. After reset a clearing pass writes white
// to every pixel, one per cycle, while input ready is low. A command then
// reduces its heading mod 360 and checks bounds, after which: line and square
// write one pixel per cycle, copy reads then writes each pixel on the one
// memory port, the ellipse visits every pixel on the shared multiplier of the
// focal unit, and shade change and pixel read paint nothing. One command is in
// flight at a time; the result register lets the next command start while the
// last result waits to be taken.
// depends on crde_pkg and crde_focal_unit
module canvas_raster_draw_engine
    import crde_pkg::*;
#(
    parameter int CANVAS_ROWS = CANVAS_ROWS_DEF,
    parameter int CANVAS_COLS = CANVAS_COLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_mode,
    input  logic signed [7:0]  i_row_a,
    input  logic signed [7:0]  i_col_a,
    input  logic signed [7:0]  i_row_b,
    input  logic signed [7:0]  i_col_b,
    input  logic signed [7:0]  i_span,
    input  logic signed [11:0] i_heading,
    input  logic signed [11:0] i_half_axis_q4,
    input  logic               i_filled,
    input  logic signed [4:0]  i_shade_delta,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_accepted,
    output logic [2:0]         o_pixel_shade,
    output logic [2:0]         o_current_shade
);

    localparam int DEPTH = CANVAS_ROWS * CANVAS_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
    localparam int CW    = (CANVAS_COLS > 1) ? $clog2(CANVAS_COLS) : 1;
    localparam logic signed [11:0] ROWS_S = 12'(CANVAS_ROWS);
    localparam logic signed [11:0] COLS_S = 12'(CANVAS_COLS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic signed [7:0] LAST_ROW = 8'(CANVAS_ROWS - 1);
    localparam logic signed [7:0] LAST_COL = 8'(CANVAS_COLS - 1);
    localparam logic [12:0] FULL_13 = 13'(ANG_FULL);

    t_state r_state, n_state;

    // captured command
    t_mode             r_mode;
    logic signed [7:0] r_ra, r_ca, r_rb, r_cb, r_sp;
    logic signed [11:0] r_hq;
    logic              r_fill;
    logic signed [4:0] r_dl;
    logic              r_s0, r_s1;
    logic [11:0]       r_m0, n_m0;
    logic [12:0]       r_m1, n_m1;

    logic [2:0] r_pen, n_pen;

    // walker
    logic signed [7:0] r_pr, r_pc, r_qr, r_qc, r_pc0, r_qc0;
    logic signed [7:0] n_pr, n_pc, n_qr, n_qc, n_pc0, n_qc0;
    logic signed [1:0] r_isr, r_isc, r_odr, n_isr, n_isc, n_odr;
    logic [7:0] r_j, r_i, r_jmax, r_imax, n_j, n_i, n_jmax, n_imax;
    logic       r_copy, n_copy;
    logic       r_fstart, n_fstart;

    logic [AW-1:0] r_clr, n_clr;

    logic       r_res_ok, n_res_ok;
    logic [2:0] r_res_pix, n_res_pix;
    logic       r_ovalid, n_ovalid;
    logic       r_oacc, n_oacc;
    logic [2:0] r_opix, n_opix, r_ocur, n_ocur;

    // memory port
    logic [2:0]    r_mem [DEPTH];
    logic [2:0]    r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [2:0]    mem_wd;

    t_focal_stat   fstat;

    logic          accept_in;
    logic          red_done;
    logic          v0, v1;
    logic [2:0]    k0, k1;
    logic signed [9:0] sp10, len_line;
    logic          v_line;
    logic [2:0]    k_line;
    logic          line_ok, fit_src, fit_dst;
    logic signed [5:0] shade_sum;
    logic          shade_ok;
    logic          walk_last_j, walk_last;
    logic          ell_last;
    t_state        dec_go;
    logic          dec_ok;
    logic          dec_block;

    function automatic logic inside_px(input logic signed [11:0] r, c);
        return (r >= 12'sd0) && (r < ROWS_S) && (c >= 12'sd0) && (c < COLS_S);
    endfunction

    function automatic logic fits(input logic signed [7:0] r, c,
                                  input logic signed [9:0] len,
                                  input logic v, input logic [2:0] k);
        logic signed [11:0] rr, cc, d, rm, rp, cm, cp;
        logic up_ok, dn_ok, lf_ok, rt_ok, f;
        rr = 12'(r);
        cc = 12'(c);
        d  = 12'(len) - 12'sd1;
        rm = rr - d;
        rp = rr + d;
        cm = cc - d;
        cp = cc + d;
        up_ok = rm >= 12'sd0;
        dn_ok = rp < ROWS_S;
        lf_ok = cm >= 12'sd0;
        rt_ok = cp < COLS_S;
        case (k)
            3'd0:    f = up_ok;
            3'd1:    f = up_ok && rt_ok;
            3'd2:    f = rt_ok;
            3'd3:    f = dn_ok && rt_ok;
            3'd4:    f = dn_ok;
            3'd5:    f = dn_ok && lf_ok;
            3'd6:    f = lf_ok;
            default: f = up_ok && lf_ok;
        endcase
        return v && inside_px(rr, cc) && f;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic signed [7:0] r, c);
        logic [RW-1:0] ru;
        logic [CW-1:0] cu;
        ru = r[RW-1:0];
        cu = c[CW-1:0];
        return AW'(AW'(ru) * AW'(CANVAS_COLS) + AW'(cu));
    endfunction

    // angle valid when a multiple of 45 whose remainder mod 360 is non-negative
    function automatic logic [3:0] ang_decode(input logic neg, input logic [8:0] m);
        logic       v;
        logic [2:0] k;
        v = 1'b0;
        k = 3'd0;
        for (int n = 0; n < 8; n++) begin
            if (m == 9'(n * ANG_STEP)) begin
                v = 1'b1;
                k = 3'(n);
            end
        end
        return {v && !(neg && (m != 9'd0)), k};
    endfunction

    crde_focal_unit u_focal (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_fstart),
        .i_row_1   (r_ra),
        .i_col_1   (r_ca),
        .i_row_2   (r_rb),
        .i_col_2   (r_cb),
        .i_half_q4 (r_hq),
        .i_filled  (r_fill),
        .i_pix_row (r_pr),
        .i_pix_col (r_pc),
        .o_stat    (fstat)
    );

    assign o_ready   = (r_state == S_IDLE);
    assign accept_in = i_valid && o_ready;
    assign red_done  = (r_m0 < 12'(ANG_FULL)) && (r_m1 < FULL_13);

    assign {v0, k0} = ang_decode(r_s0, r_m0[8:0]);
    assign {v1, k1} = ang_decode(r_s1, r_m1[8:0]);

    // negative line length flips the heading by 180
    assign sp10     = 10'(r_sp);
    assign len_line = r_sp[7] ? -sp10 : sp10;
    assign v_line   = r_sp[7] ? v1 : v0;
    assign k_line   = r_sp[7] ? k1 : k0;
    assign line_ok  = (len_line != 10'sd0) && fits(r_ra, r_ca, len_line, v_line, k_line);
    assign fit_src  = fits(r_ra, r_ca, sp10, v0, k0);
    assign fit_dst  = fits(r_rb, r_cb, sp10, v0, k0);

    assign shade_sum = $signed({3'b000, r_pen}) + 6'(r_dl);
    assign shade_ok  = (shade_sum >= 6'sd0) && (shade_sum <= 6'(SHADE_MAX));

    assign walk_last_j = (9'(r_j) + 9'd1) >= 9'(r_jmax);
    assign walk_last   = walk_last_j && ((9'(r_i) + 9'd1) >= 9'(r_imax));
    assign ell_last    = (r_pr == LAST_ROW) && (r_pc == LAST_COL);

    // command decision
    always_comb begin
        dec_ok    = 1'b0;
        dec_go    = S_DONE;
        dec_block = 1'b0;
        unique case (r_mode)
            MODE_ELLIPSE: begin
                dec_ok = 1'b1;
                dec_go = S_ELL;
            end
            MODE_LINE: begin
                dec_ok = line_ok;
                dec_go = line_ok ? S_WALK : S_DONE;
            end
            MODE_SQUARE: begin
                if (!fit_src) begin
                    dec_ok = 1'b0;
                end else if (!k0[0]) begin
                    dec_ok = line_ok;
                    dec_go = line_ok ? S_WALK : S_DONE;
                end else begin
                    dec_ok    = !r_sp[7] && (r_sp != 8'sd0);
                    dec_go    = dec_ok ? S_WALK : S_DONE;
                    dec_block = 1'b1;
                end
            end
            MODE_SHADE: dec_ok = shade_ok;
            MODE_COPY: begin
                dec_ok    = fit_src && fit_dst && k0[0] && !r_sp[7] && (r_sp != 8'sd0);
                dec_go    = dec_ok ? S_WALK : S_DONE;
                dec_block = 1'b1;
            end
            MODE_READ: begin
                dec_ok = inside_px(12'(r_ra), 12'(r_ca));
                dec_go = dec_ok ? S_RDWAIT : S_DONE;
            end
            default: dec_ok = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == LAST_ADDR) n_state = S_IDLE;
            S_IDLE:   if (accept_in) n_state = S_REDUCE;
            S_REDUCE: if (red_done) n_state = S_DECIDE;
            S_DECIDE: n_state = dec_go;
            S_WALK:   if (r_copy) n_state = S_CPWR;
                      else if (walk_last) n_state = S_DONE;
            S_CPWR:   n_state = walk_last ? S_DONE : S_WALK;
            S_ELL:    if (fstat.done && ell_last) n_state = S_DONE;
            S_RDWAIT: n_state = S_DONE;
            S_DONE:   if (!r_ovalid || i_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_m0 = r_m0;  n_m1 = r_m1;
        n_pen = r_pen;
        n_pr = r_pr;  n_pc = r_pc;  n_qr = r_qr;  n_qc = r_qc;
        n_pc0 = r_pc0; n_qc0 = r_qc0;
        n_isr = r_isr; n_isc = r_isc; n_odr = r_odr;
        n_j = r_j; n_i = r_i; n_jmax = r_jmax; n_imax = r_imax;
        n_copy = r_copy;
        n_fstart = 1'b0;
        n_clr = r_clr;
        n_res_ok = r_res_ok;
        n_res_pix = r_res_pix;
        n_ovalid = r_ovalid && !i_ready;
        n_oacc = r_oacc; n_opix = r_opix; n_ocur = r_ocur;
        mem_we = 1'b0;
        mem_addr = addr_of(r_pr, r_pc);
        mem_wd = r_pen;

        unique case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
                mem_wd   = SHADE_WHITE;
                n_clr    = r_clr + AW'(1);
            end
            S_REDUCE: begin
                if (r_m0 >= 12'(ANG_FULL)) n_m0 = r_m0 - 12'(ANG_FULL);
                if (r_m1 >= FULL_13) n_m1 = r_m1 - FULL_13;
            end
            S_DECIDE: begin
                n_res_ok  = dec_ok;
                n_res_pix = 3'd0;
                n_j = 8'd0;
                n_i = 8'd0;
                n_copy = (r_mode == MODE_COPY);
                if (dec_block) begin
                    n_isr = 2'sd0;
                    n_isc = (k0 == 3'd1 || k0 == 3'd3) ? 2'sd1 : -2'sd1;
                    n_odr = (k0 == 3'd1 || k0 == 3'd7) ? -2'sd1 : 2'sd1;
                    n_jmax = r_sp;
                    n_imax = r_sp;
                end else begin
                    n_isr = step_row(k_line);
                    n_isc = step_col(k_line);
                    n_odr = 2'sd0;
                    n_jmax = len_line[7:0];
                    n_imax = 8'd1;
                end
                if (r_mode == MODE_COPY) begin
                    n_pr = r_rb; n_pc = r_cb; n_pc0 = r_cb;
                end else begin
                    n_pr = r_ra; n_pc = r_ca; n_pc0 = r_ca;
                end
                n_qr = r_ra; n_qc = r_ca; n_qc0 = r_ca;
                if (r_mode == MODE_ELLIPSE) begin
                    n_pr = 8'sd0;
                    n_pc = 8'sd0;
                    n_fstart = 1'b1;
                end
                if (r_mode == MODE_SHADE && shade_ok) n_pen = shade_sum[2:0];
                // read issued here, data lands next cycle
                mem_addr = addr_of(r_ra, r_ca);
            end
            S_WALK: begin
                if (r_copy) begin
                    mem_addr = addr_of(r_qr, r_qc);
                end else begin
                    mem_we = 1'b1;
                end
            end
            S_CPWR: begin
                mem_we = 1'b1;
                mem_wd = r_rdata;
            end
            S_ELL: begin
                if (fstat.done) begin
                    mem_we = fstat.hit;
                    if (!ell_last) begin
                        n_fstart = 1'b1;
                        if (r_pc == LAST_COL) begin
                            n_pc = 8'sd0;
                            n_pr = r_pr + 8'sd1;
                        end else begin
                            n_pc = r_pc + 8'sd1;
                        end
                    end
                end
            end
            S_RDWAIT: n_res_pix = r_rdata;
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_oacc   = r_res_ok;
                    n_opix   = r_res_pix;
                    n_ocur   = r_pen;
                end
            end
            default: ;
        endcase

        // step to the next pixel of a line or block
        if ((r_state == S_WALK && !r_copy) || r_state == S_CPWR) begin
            if (!walk_last_j) begin
                n_j  = r_j + 8'd1;
                n_pr = r_pr + 8'(r_isr);
                n_pc = r_pc + 8'(r_isc);
                n_qr = r_qr + 8'(r_isr);
                n_qc = r_qc + 8'(r_isc);
            end else begin
                n_j  = 8'd0;
                n_i  = r_i + 8'd1;
                n_pr = r_pr + 8'(r_odr);
                n_pc = r_pc0;
                n_qr = r_qr + 8'(r_odr);
                n_qc = r_qc0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wd;
        r_rdata <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pen    <= 3'd0;
            r_ovalid <= 1'b0;
            r_fstart <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_pen    <= n_pen;
            r_ovalid <= n_ovalid;
            r_fstart <= n_fstart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_mode <= t_mode'(i_mode);
            r_ra   <= i_row_a;
            r_ca   <= i_col_a;
            r_rb   <= i_row_b;
            r_cb   <= i_col_b;
            r_sp   <= i_span;
            r_hq   <= i_half_axis_q4;
            r_fill <= i_filled;
            r_dl   <= i_shade_delta;
            r_s0   <= i_heading[11];
            r_m0   <= i_heading[11] ? 12'(-13'(i_heading)) : 12'(i_heading);
            r_s1   <= (13'(i_heading) + 13'(ANG_HALF)) < 13'sd0;
            r_m1   <= ((13'(i_heading) + 13'(ANG_HALF)) < 13'sd0)
                      ? 13'(-(13'(i_heading) + 13'(ANG_HALF)))
                      : 13'(13'(i_heading) + 13'(ANG_HALF));
        end else begin
            r_m0 <= n_m0;
            r_m1 <= n_m1;
        end
        r_pr <= n_pr;  r_pc <= n_pc;  r_qr <= n_qr;  r_qc <= n_qc;
        r_pc0 <= n_pc0; r_qc0 <= n_qc0;
        r_isr <= n_isr; r_isc <= n_isc; r_odr <= n_odr;
        r_j <= n_j; r_i <= n_i; r_jmax <= n_jmax; r_imax <= n_imax;
        r_copy <= n_copy;
        r_res_ok <= n_res_ok;
        r_res_pix <= n_res_pix;
        r_oacc <= n_oacc; r_opix <= n_opix; r_ocur <= n_ocur;
    end

    assign o_valid         = r_ovalid;
    assign o_accepted      = r_oacc;
    assign o_pixel_shade   = r_opix;
    assign o_current_shade = r_ocur;

endmodule

/* rtl/crde_checker.sv */
// port-level checks for the raster draw engine, bound to the top level
// depends on canvas_raster_draw_engine_defines.svh
`include "canvas_raster_draw_engine_defines.svh"
module crde_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_accepted,
    input logic [2:0] o_pixel_shade,
    input logic [2:0] o_current_shade
);

    // a result beat waits until taken
    `CRDE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    // one command at a time: busy right after an input beat
    `CRDE_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    // a refused command reports no pixel
    `CRDE_ASSERT_NOW(a_pix_needs_ok, i_clk, i_rst_n, o_valid && !o_accepted,
        o_pixel_shade == 3'd0)
    // shades stay in the black to white range
    `CRDE_ASSERT_NOW(a_shade_range, i_clk, i_rst_n, o_valid,
        (o_current_shade <= 3'd4) && (o_pixel_shade <= 3'd4))

endmodule

bind canvas_raster_draw_engine crde_checker u_crde_checker (.*);

/* tb/canvas_raster_draw_engine_tb.sv */
// self-checking testbench for the raster draw engine: a directed table, then random
// commands, each result checked against typed expectations or a behavioral canvas predictor
// depends on crde_pkg and canvas_raster_draw_engine
`timescale 1ns / 100ps

module canvas_raster_draw_engine_tb;
    import crde_pkg::*;

    localparam int ROWS      = 32;
    localparam int COLS      = 64;
    localparam int N_RANDOM  = 265;
    localparam int IDLE_LIMIT = 120000;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    typedef struct {
        logic [2:0]         mode;
        logic signed [7:0]  ra;
        logic signed [7:0]  ca;
        logic signed [7:0]  rb;
        logic signed [7:0]  cb;
        logic signed [7:0]  span;
        logic signed [11:0] heading;
        logic signed [11:0] half_q4;
        logic               filled;
        logic signed [4:0]  delta;
    } t_cmd;

    typedef struct {
        logic       acc;
        logic [2:0] pix;
        logic [2:0] cur;
    } t_res;

    typedef struct {
        t_cmd cmd;
        bit   typed;
        t_res res;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_mode = '0;
    logic signed [7:0]  i_row_a = '0;
    logic signed [7:0]  i_col_a = '0;
    logic signed [7:0]  i_row_b = '0;
    logic signed [7:0]  i_col_b = '0;
    logic signed [7:0]  i_span = '0;
    logic signed [11:0] i_heading = '0;
    logic signed [11:0] i_half_axis_q4 = '0;
    logic               i_filled = 1'b0;
    logic signed [4:0]  i_shade_delta = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_accepted;
    logic [2:0]         o_pixel_shade;
    logic [2:0]         o_current_shade;

    canvas_raster_draw_engine dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predicted canvas and pen
    logic [2:0] pic [ROWS*COLS];
    logic [2:0] pen;
    t_res       pending_q[$];
    int         errors = 0;
    int         results_seen = 0;
    int         mode_count [8];
    bit         quiet = 1'b0;

    function automatic bit on_canvas(int r, int c);
        return r >= 0 && r < ROWS && c >= 0 && c < COLS;
    endfunction

    function automatic bit fits(int r, int c, int len, int hd);
        int d, a;
        d = len - 1;
        a = hd % 360;
        if (!on_canvas(r, c) || a < 0 || a % 45 != 0) return 0;
        case (a)
            0:   return r - d >= 0;
            45:  return r - d >= 0 && c + d < COLS;
            90:  return c + d < COLS;
            135: return r + d < ROWS && c + d < COLS;
            180: return r + d < ROWS;
            225: return r + d < ROWS && c - d >= 0;
            270: return c - d >= 0;
            default: return r - d >= 0 && c - d >= 0;
        endcase
    endfunction

    function automatic bit paint_line(int r, int c, int len, int hd);
        int k;
        if (len < 0) begin
            len = -len;
            hd += 180;
        end
        if (len <= 0 || !fits(r, c, len, hd)) return 0;
        k = (hd % 360) / 45;
        for (int i = 0; i < len; i++) begin
            if (on_canvas(r, c)) pic[r*COLS + c] = pen;
            r += step_row(k[2:0]);
            c += step_col(k[2:0]);
        end
        return 1;
    endfunction

    function automatic bit paint_square(int r, int c, int len, int hd);
        int a, dir, dr;
        bit unused;
        a = hd % 360;
        if (!fits(r, c, len, hd)) return 0;
        if (a % 90 == 0) return paint_line(r, c, len, hd);
        if (len <= 0) return 0;
        dir = (a == 45 || a == 135) ? 90 : 270;
        dr  = (a == 45 || a == 315) ? -1 : 1;
        for (int i = 0; i < len; i++) begin
            unused = paint_line(r, c, len, dir);
            r += dr;
        end
        return 1;
    endfunction

    function automatic bit copy_diag(int sr, int sc, int tr, int tc, int len, int hd);
        int a, dr, dc, r0, c0, r1, c1;
        a = hd % 360;
        if (!fits(tr, tc, len, hd) || !fits(sr, sc, len, hd)) return 0;
        if (a % 90 == 0 || len <= 0) return 0;
        dc = (a == 45 || a == 135) ? 1 : -1;
        dr = (a == 45 || a == 315) ? -1 : 1;
        for (int i = 0; i < len; i++)
            for (int j = 0; j < len; j++) begin
                r0 = sr + dr*i; c0 = sc + dc*j;
                r1 = tr + dr*i; c1 = tc + dc*j;
                if (on_canvas(r0, c0) && on_canvas(r1, c1))
                    pic[r1*COLS + c1] = pic[r0*COLS + c0];
            end
        return 1;
    endfunction

    // sqrt(da) + sqrt(db) against h, squared out so it stays exact
    function automatic bit focal_hit(longint da, longint db, longint h, bit fill);
        longint cc;
        if (h < 0 || h*h < db) return 0;
        cc = h*h + db - da;
        if (cc < 0) return 0;
        return fill ? (4*h*h*db <= cc*cc) : (4*h*h*db == cc*cc);
    endfunction

    function automatic void paint_ellipse(int r1, int c1, int r2, int c2, int h, bit fill);
        longint a1, b1, a2, b2;
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++) begin
                a1 = r1 - r; b1 = c1 - c; a2 = r2 - r; b2 = c2 - c;
                if (focal_hit(64*(a1*a1 + b1*b1), 64*(a2*a2 + b2*b2), h, fill))
                    pic[r*COLS + c] = pen;
            end
    endfunction

    function automatic t_res predict_command(t_cmd m);
        t_res o;
        int   s;
        o.acc = 0;
        o.pix = '0;
        case (m.mode)
            MODE_ELLIPSE: begin
                paint_ellipse(m.ra, m.ca, m.rb, m.cb, m.half_q4, m.filled);
                o.acc = 1;
            end
            MODE_LINE:   o.acc = paint_line(m.ra, m.ca, m.span, m.heading);
            MODE_SQUARE: o.acc = paint_square(m.ra, m.ca, m.span, m.heading);
            MODE_SHADE: begin
                s = int'(pen) + m.delta;
                if (s >= 0 && s <= SHADE_MAX) begin
                    pen = s[2:0];
                    o.acc = 1;
                end
            end
            MODE_COPY: o.acc = copy_diag(m.ra, m.ca, m.rb, m.cb, m.span, m.heading);
            MODE_READ:
                if (on_canvas(m.ra, m.ca)) begin
                    o.pix = pic[int'(m.ra)*COLS + m.ca];
                    o.acc = 1;
                end
            default: ;
        endcase
        o.cur = pen;
        return o;
    endfunction

    function automatic t_row row(logic [2:0] md, int ra, int ca, int rb, int cb, int sp,
                                 int hd, int hq, bit fl, int dl,
                                 bit typed = 0, bit acc = 0, int pix = 0, int cur = 0);
        t_row t;
        t.cmd = '{md, 8'(ra), 8'(ca), 8'(rb), 8'(cb), 8'(sp), 12'(hd), 12'(hq), fl, 5'(dl)};
        t.typed = typed;
        t.res = '{acc, 3'(pix), 3'(cur)};
        return t;
    endfunction

    function automatic t_cmd random_command();
        t_cmd m;
        int   pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 4) == 0) begin
            // raw noise across every bit
            m = '{3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 12'($urandom), 12'($urandom), 1'($urandom), 5'($urandom)};
            // keep the slow ellipse rare
            if (m.mode == MODE_ELLIPSE && $urandom_range(0, 3) != 0) m.mode = MODE_READ;
            return m;
        end
        m.mode = pick < 4  ? MODE_ELLIPSE : pick < 28 ? MODE_LINE : pick < 48 ? MODE_SQUARE :
                 pick < 60 ? MODE_SHADE   : pick < 78 ? MODE_COPY : pick < 95 ? MODE_READ :
                 (pick[0] ? MODE_SPARE6 : MODE_SPARE7);
        m.ra = 8'($urandom_range(0, ROWS-1));
        m.ca = 8'($urandom_range(0, COLS-1));
        m.rb = 8'($urandom_range(0, ROWS-1));
        m.cb = 8'($urandom_range(0, COLS-1));
        m.span = $urandom_range(0, 5) == 0 ? 8'(-int'($urandom_range(0, 8)))
                                           : 8'($urandom_range(1, 10));
        m.heading = 12'(45*$urandom_range(0, 7) + 360*$urandom_range(0, 4));
        if ($urandom_range(0, 9) == 0) m.heading = 12'(-int'(m.heading));
        m.half_q4 = 12'($urandom_range(0, 420));
        m.filled  = 1'($urandom);
        m.delta   = 5'(int'($urandom_range(0, 6)) - 3);
        return m;
    endfunction

    task automatic issue(t_cmd m, bit typed, t_res want);
        t_res got;
        i_mode <= m.mode;   i_row_a <= m.ra;     i_col_a <= m.ca;
        i_row_b <= m.rb;    i_col_b <= m.cb;     i_span <= m.span;
        i_heading <= m.heading;  i_half_axis_q4 <= m.half_q4;
        i_filled <= m.filled;    i_shade_delta <= m.delta;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        got = predict_command(m);
        pending_q.push_back(typed ? want : got);
        mode_count[m.mode]++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // receiver stalls in bursts
    int hold_rx = 0;
    always @(posedge i_clk) begin
        if (hold_rx > 0) begin
            hold_rx <= hold_rx - 1;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            hold_rx <= $urandom_range(0, 16);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // result beat check
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_q.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (o_accepted !== e.acc) begin
                    $error("accepted: expected %0d got %0d", e.acc, o_accepted);
                    errors++;
                end
                if (o_pixel_shade !== e.pix) begin
                    $error("pixel_shade: expected %0d got %0d", e.pix, o_pixel_shade);
                    errors++;
                end
                if (o_current_shade !== e.cur) begin
                    $error("current_shade: expected %0d got %0d", e.cur, o_current_shade);
                    errors++;
                end
            end
        end
    end

    // covers the clearing pass and the slowest ellipse
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    t_row directed [] = '{
        row(MODE_READ,    0,    0, 0, 0, 0, 0, 0, 0, 0,  1, 1, 4, 0),
        row(MODE_READ, -128, -128, 0, 0, 0, 0, 0, 0, 0,  1, 0, 0, 0),
        row(MODE_READ,   31,   63, 0, 0, 0, 0, 0, 0, 0,  1, 1, 4, 0),
        row(MODE_READ,   32,    0, 0, 0, 0, 0, 0, 0, 0,  1, 0, 0, 0),
        row(MODE_READ,  127,  127, 0, 0, 0, 0, 0, 0, 0,  1, 0, 0, 0),
        row(MODE_SPARE6,  1,    1, 0, 0, 1, 0, 0, 0, 0,  1, 0, 0, 0),
        row(MODE_SPARE7,  1,    1, 0, 0, 1, 0, 0, 0, 0,  1, 0, 0, 0),
        row(MODE_SHADE,   0,    0, 0, 0, 0, 0, 0, 0, 5,  1, 0, 0, 0),
        row(MODE_SHADE,   0,    0, 0, 0, 0, 0, 0, 0, -16, 1, 0, 0, 0),
        row(MODE_SHADE,   0,    0, 0, 0, 0, 0, 0, 0, 4,  1, 1, 0, 4),
        row(MODE_SHADE,   0,    0, 0, 0, 0, 0, 0, 0, 15, 1, 0, 0, 4),
        row(MODE_SHADE,   0,    0, 0, 0, 0, 0, 0, 0, -3, 1, 1, 0, 1),
        row(MODE_LINE,    0,    0, 0, 0, 127, 90, 0, 0, 0, 1, 0, 0, 1),
        row(MODE_LINE,    5,    5, 0, 0, 0, 90, 0, 0, 0,  1, 0, 0, 1),
        row(MODE_LINE,   10,   10, 0, 0, -128, 0, 0, 0, 0, 1, 0, 0, 1),
        row(MODE_LINE,   10,   10, 0, 0, 3, -2048, 0, 0, 0, 1, 0, 0, 1),
        row(MODE_LINE,   10,   10, 0, 0, 3, 2047, 0, 0, 0, 1, 0, 0, 1),
        row(MODE_LINE,   10,   10, 0, 0, 5, 45, 0, 0, 0),
        row(MODE_LINE,   10,   20, 0, 0, -4, 2025, 0, 0, 0),
        row(MODE_SQUARE,  2,    2, 0, 0, 4, 135, 0, 0, 0),
        row(MODE_SQUARE, 20,   40, 0, 0, 6, 270, 0, 0, 0),
        row(MODE_COPY,    2,    2, 10, 30, 4, 135, 0, 0, 0),
        row(MODE_COPY,    2,    2, 10, 30, 4, 90, 0, 0, 0),
        row(MODE_ELLIPSE, 8,    8, 8, 16, 0, 0, 96, 1, 0),
        row(MODE_ELLIPSE, 8,    8, 8, 16, 0, 0, 64, 0, 0),
        row(MODE_ELLIPSE, 8,    8, 8, 16, 0, 0, -2048, 1, 0),
        row(MODE_READ,   10,   10, 0, 0, 0, 0, 0, 0, 0)
    };

    initial begin
        int rem;
        t_res none;
        for (int i = 0; i < ROWS*COLS; i++) pic[i] = SHADE_WHITE;
        pen = '0;
        none = '{1'b0, 3'd0, 3'd0};
        foreach (mode_count[k]) mode_count[k] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[i]) issue(directed[i].cmd, directed[i].typed, directed[i].res);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 40) quiet = 1'b1;
            issue(random_command(), 1'b0, none);
        end
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        rem = pending_q.size();
        $display("commands: ellipse %0d line %0d square %0d shade %0d copy %0d read %0d other %0d",
                 mode_count[0], mode_count[1], mode_count[2], mode_count[3],
                 mode_count[4], mode_count[5], mode_count[6] + mode_count[7]);
        $display("result beats checked: %0d, left waiting: %0d", results_seen, rem);
        if (errors == 0 && rem == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
